[rtl/huffman_table_encoder_assert.svh]
// Assertion macros for the huffman_table_encoder blocks.
// Used by the datapath; expects signals named clock and reset in scope.
`ifndef HUFFMAN_TABLE_ENCODER_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define HTE_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define HTE_ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);

`endif

[rtl/hte_pkg.sv]
// Package for the huffman_table_encoder: sizes, codes and the control/status
// structs between controller and datapath. No dependencies.
package hte_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int MAX_CODE_BITS = 32;
   localparam int CODE_W        = 32;
   localparam int LEN_LIMIT     = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
   localparam int TABLE_DEPTH   = ALPHABET_SIZE + 1;

   localparam int CMD_W  = 2;
   localparam int SYM_W  = 9;
   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;
   localparam int PEND_W = 7;
   localparam int CNT_W  = 3;
   localparam int ACC_W  = PEND_W + CODE_W;
   localparam int TOT_W  = 6;

   localparam logic [SYM_W-1:0] EOS_SYMBOL = SYM_W'(ALPHABET_SIZE);

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef struct packed {
      logic accept;
      logic err_emit;
      logic combine;
      logic byte_emit;
      logic flush_emit;
      logic finish;
   } hte_ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] req_command;
      logic [CMD_W-1:0] command;
      logic             no_code;
      logic             total_ge8;
      logic             total_zero;
      logic             out_free;
   } hte_sts_type;

endpackage

[rtl/hte_req_if.sv]
// Request channel of the huffman_table_encoder: valid/ready plus item fields.
// Depends on hte_pkg.
interface hte_req_if;
   import hte_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [SYM_W-1:0]  symbol;
   logic [LEN_W-1:0]  code_length;
   logic [CODE_W-1:0] code_word;

   modport source (output valid, command, symbol, code_length, code_word, input ready);
   modport sink   (input valid, command, symbol, code_length, code_word, output ready);
endinterface

[rtl/hte_rsp_if.sv]
// Response channel of the huffman_table_encoder: valid/ready plus result fields.
// Depends on hte_pkg.
interface hte_rsp_if;
   import hte_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] data_byte;
   logic              last;

   modport source (output valid, kind, data_byte, last, input ready);
   modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

[rtl/huffman_table_encoder.sv]
// Table-driven Huffman encoder with MSB-first byte packing. A load item is
// taken in the idle state. An encode item passes a registered code table read
// and a combine step, then emits the n full bytes it yields (n up to 4); an end
// item likewise, plus one more byte when a partial byte is flushed, and an error
// report is loaded in the lookup state. Bytes leave through the single result
// register, one byte per cycle unless the result channel stalls. Table entries
// are cleared at reset at once by per-entry valid bits, so no clearing pass runs.
// Depends on hte_pkg, hte_req_if, hte_rsp_if, hte_ctrl and hte_datapath.
module huffman_table_encoder (
   input logic       clock,
   input logic       reset,
   hte_req_if.sink   req_chan,
   hte_rsp_if.source rsp_chan
);
   import hte_pkg::*;

   hte_ctl_type ctl;
   hte_sts_type sts;
   logic        req_ready;

   hte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   hte_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_command     (req_chan.command),
      .req_symbol      (req_chan.symbol),
      .req_code_length (req_chan.code_length),
      .req_code_word   (req_chan.code_word),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_kind        (rsp_chan.kind),
      .rsp_data_byte   (rsp_chan.data_byte),
      .rsp_last        (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;

endmodule

[rtl/hte_ctrl.sv]
// Controller FSM of the huffman_table_encoder: sequences accept, table
// lookup, error report, byte emission and flush. Depends on hte_pkg.
module hte_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output hte_pkg::hte_ctl_type ctl,
   input  hte_pkg::hte_sts_type sts
);
   import hte_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;
   localparam logic [1:0] S_FLUSH  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               if (sts.req_command inside {CMD_ENCODE, CMD_END}) begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            if (sts.command == CMD_ENCODE && sts.no_code) begin
               if (sts.out_free) begin
                  ctl.err_emit = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               ctl.combine = 1'b1;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.total_ge8) begin
               ctl.byte_emit = sts.out_free;
            end else if (sts.command == CMD_END && !sts.total_zero) begin
               state_in = S_FLUSH;
            end else begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               ctl.flush_emit = 1'b1;
               ctl.finish     = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/hte_datapath.sv]
// Datapath of the huffman_table_encoder: code table memory, bit accumulator,
// pending buffer and result register. Depends on hte_pkg and the assert header.
`include "huffman_table_encoder_assert.svh"

module hte_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  hte_pkg::hte_ctl_type ctl,
   output hte_pkg::hte_sts_type sts,
   input  logic [hte_pkg::CMD_W-1:0]  req_command,
   input  logic [hte_pkg::SYM_W-1:0]  req_symbol,
   input  logic [hte_pkg::LEN_W-1:0]  req_code_length,
   input  logic [hte_pkg::CODE_W-1:0] req_code_word,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_kind,
   output logic [hte_pkg::BYTE_W-1:0] rsp_data_byte,
   output logic                 rsp_last
);
   import hte_pkg::*;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   entry_type              code_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   entry_type              rd_entry_ff;
   logic                   rd_hit_ff;

   logic [CMD_W-1:0]  command_ff;
   logic              sym_oor_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;
   logic [CNT_W-1:0]  pend_count_ff, pend_count_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic [LEN_W-1:0]  load_len;
   logic [CODE_W-1:0] load_mask;
   logic              load_we;
   logic              rd_en;
   logic [SYM_W-1:0]  rd_addr;
   logic [LEN_W-1:0]  cur_len;
   logic [CODE_W-1:0] cur_code;
   logic [TOT_W-1:0]  remaining;
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_last;
   logic [3:0]        flush_shift;
   logic [BYTE_W+PEND_W-1:0] flush_wide;
   logic              out_free;

   // table write and lookup
   always_comb begin
      load_len  = (req_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : req_code_length;
      load_mask = (load_len >= LEN_W'(CODE_W)) ? '1 : ~({CODE_W{1'b1}} << load_len);
      load_we   = ctl.accept && req_command == CMD_LOAD && req_symbol <= EOS_SYMBOL;
      rd_en     = ctl.accept && (req_command == CMD_END ||
                  (req_command == CMD_ENCODE && req_symbol < EOS_SYMBOL));
      rd_addr   = (req_command == CMD_END) ? EOS_SYMBOL : req_symbol;
      cur_len   = rd_hit_ff ? rd_entry_ff.len : '0;
      cur_code  = rd_hit_ff ? rd_entry_ff.code : '0;
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         code_mem[req_symbol] <= '{len: load_len, code: req_code_word & load_mask};
      end
      if (rd_en) begin
         rd_entry_ff <= code_mem[rd_addr];
         rd_hit_ff   <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (load_we) begin
         valid_ff[req_symbol] <= 1'b1;
      end
   end

   // bit packing
   always_comb begin
      remaining   = total_ff - TOT_W'(BYTE_W);
      emit_byte   = BYTE_W'(acc_ff >> remaining);
      emit_last   = (command_ff == CMD_END) ? (remaining == '0)
                                            : (remaining < TOT_W'(BYTE_W));
      flush_shift = 4'(BYTE_W) - {1'b0, total_ff[CNT_W-1:0]};
      flush_wide  = (BYTE_W+PEND_W)'(acc_ff[PEND_W-1:0]) << flush_shift;

      acc_in   = acc_ff;
      total_in = total_ff;
      if (ctl.combine) begin
         acc_in   = (ACC_W'(pend_bits_ff) << cur_len) | ACC_W'(cur_code);
         total_in = TOT_W'(pend_count_ff) + TOT_W'(cur_len);
      end else if (ctl.byte_emit) begin
         total_in = remaining;
      end

      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      if (ctl.finish) begin
         if (command_ff == CMD_END) begin
            pend_bits_in  = '0;
            pend_count_in = '0;
         end else begin
            pend_bits_in  = acc_ff[PEND_W-1:0] & ~({PEND_W{1'b1}} << total_ff[CNT_W-1:0]);
            pend_count_in = total_ff[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         command_ff <= req_command;
         sym_oor_ff <= req_symbol >= EOS_SYMBOL;
      end
      acc_ff   <= acc_in;
      total_ff <= total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
      end else begin
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
      end
   end

   // result register
   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (ctl.err_emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_ERROR;
         out_byte_in  = '0;
         out_last_in  = 1'b1;
      end else if (ctl.byte_emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_DATA;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end else if (ctl.flush_emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_DATA;
         out_byte_in  = flush_wide[BYTE_W-1:0];
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_data_byte = out_byte_ff;
   assign rsp_last      = out_last_ff;

   always_comb begin
      sts.req_command = req_command;
      sts.command     = command_ff;
      sts.no_code     = sym_oor_ff || cur_len == '0;
      sts.total_ge8   = total_ff >= TOT_W'(BYTE_W);
      sts.total_zero  = total_ff == '0;
      sts.out_free    = out_free;
   end

   `HTE_ASSERT_ALWAYS(a_err_shape,
      !(out_valid_ff && out_kind_ff == KIND_ERROR) || (out_byte_ff == '0 && out_last_ff),
      "error report must carry a zero byte and last")
   `HTE_ASSERT_ALWAYS(a_emit_free,
      !(ctl.err_emit || ctl.byte_emit || ctl.flush_emit) || out_free,
      "result loaded while result register still full")
   `HTE_ASSERT_ALWAYS(a_pend_clean, (pend_bits_ff >> pend_count_ff) == '0,
      "pending bits set above pending count")
   `HTE_ASSERT_NEXT(a_end_clears, ctl.finish && command_ff == CMD_END,
      pend_count_ff == '0 && pend_bits_ff == '0, "end of stream left bits pending")

endmodule

[tb/sv/huffman_table_encoder_test.sv]
// Testbench for huffman_table_encoder: directed and random load/encode/end traffic,
// with a scoreboard that predicts every packed byte and error report.
// Depends on hte_pkg, hte_req_if, hte_rsp_if and the huffman_table_encoder RTL.
`timescale 1ns / 100ps

module huffman_table_encoder_test;
   import hte_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  code_length;
      logic [CODE_W-1:0] code_word;
      logic              wait_drain;
   } enc_item_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data_byte;
      logic              last;
   } enc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hte_req_if req_chan ();
   hte_rsp_if rsp_chan ();

   huffman_table_encoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   enc_item_type   pending_items[$];
   enc_result_type expected_bytes[$];

   int accepted_items = 0;
   int offered_items = 0;
   int results_seen = 0;
   int error_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // shadow of the code table and the bit packer
   logic [LEN_W-1:0]  shadow_len [TABLE_DEPTH] = '{default: '0};
   logic [CODE_W-1:0] shadow_code [TABLE_DEPTH] = '{default: '0};
   logic [PEND_W-1:0] shadow_bits = '0;
   logic [CNT_W-1:0]  shadow_count = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void queue_item(input logic [CMD_W-1:0] cmd,
                                      input logic [SYM_W-1:0] sym,
                                      input logic [LEN_W-1:0] len,
                                      input logic [CODE_W-1:0] word,
                                      input logic drain = 1'b0);
      enc_item_type item;
      item = '{cmd, sym, len, word, drain};
      pending_items.push_back(item);
   endfunction

   task automatic predict_bytes(input logic [CMD_W-1:0] cmd,
                                input logic [SYM_W-1:0] sym,
                                input logic [LEN_W-1:0] len,
                                input logic [CODE_W-1:0] word);
      enc_result_type fresh [5];
      int n;
      int unsigned lim;
      int unsigned use_len;
      int unsigned total;
      logic [CODE_W-1:0] use_code;
      logic [63:0] acc;
      logic [BYTE_W-1:0] tail;
      bit do_pack;
      bit do_flush;
      n = 0;
      do_pack = 1'b0;
      do_flush = 1'b0;
      use_len = 0;
      use_code = '0;
      case (cmd)
         CMD_LOAD: begin
            if (sym <= ALPHABET_SIZE) begin
               lim = (32'(len) > LEN_LIMIT) ? LEN_LIMIT : 32'(len);
               shadow_len[sym] = LEN_W'(lim);
               shadow_code[sym] = (lim >= 32) ? word : (word & ((32'h1 << lim) - 32'h1));
            end
         end
         CMD_ENCODE: begin
            if (sym >= ALPHABET_SIZE || shadow_len[sym] == 0) begin
               expected_bytes.push_back('{KIND_ERROR, 8'h00, 1'b1});
            end else begin
               do_pack = 1'b1;
               use_len = 32'(shadow_len[sym]);
               use_code = shadow_code[sym];
            end
         end
         CMD_END: begin
            do_pack = 1'b1;
            do_flush = 1'b1;
            use_len = 32'(shadow_len[EOS_SYMBOL]);
            use_code = shadow_code[EOS_SYMBOL];
         end
         default: ;
      endcase
      if (do_pack) begin
         acc = (64'(shadow_bits) << use_len) | 64'(use_code);
         total = 32'(shadow_count) + use_len;
         while (total >= 8) begin
            fresh[n] = '{KIND_DATA, BYTE_W'(acc >> (total - 8)), 1'b0};
            n++;
            total -= 8;
         end
         shadow_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
         shadow_count = CNT_W'(total);
         if (do_flush) begin
            if (shadow_count != 0) begin
               tail = {1'b0, shadow_bits} << (8 - shadow_count);
               fresh[n] = '{KIND_DATA, tail, 1'b0};
               n++;
            end
            shadow_bits = '0;
            shadow_count = '0;
         end
         if (n > 0) fresh[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) expected_bytes.push_back(fresh[i]);
      end
   endtask

   // sampled at the rising edge: check results first, then predict the accepted item
   always @(posedge clock) begin : watch_channels
      enc_result_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
               $error("result with no expectation: kind %0d data_byte 0x%02h last %0d",
                      rsp_chan.kind, rsp_chan.data_byte, rsp_chan.last);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_chan.kind !== want.kind) begin
                  $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_chan.kind);
                  error_count++;
               end
               if (rsp_chan.data_byte !== want.data_byte) begin
                  $error("data_byte mismatch: expected 0x%02h, actual 0x%02h",
                         want.data_byte, rsp_chan.data_byte);
                  error_count++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_chan.last);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            accepted_items++;
            predict_bytes(req_chan.command, req_chan.symbol, req_chan.code_length,
                          req_chan.code_word);
         end
      end
   end

   always @(negedge clock) begin : drive_requests
      enc_item_type nxt;
      bit idle;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!(req_chan.valid && accepted_items < offered_items)) begin
         idle = ($urandom_range(99) < 28);
         if ((accepted_items >= 40 && accepted_items < 70) ||
             (accepted_items >= 80 && accepted_items < 100)) idle = 1'b0;
         if (pending_items.size() > 0 && pending_items[0].wait_drain &&
             expected_bytes.size() != 0) idle = 1'b1;
         if (pending_items.size() > 0 && !idle) begin
            nxt = pending_items.pop_front();
            req_chan.command <= nxt.command;
            req_chan.symbol <= nxt.symbol;
            req_chan.code_length <= nxt.code_length;
            req_chan.code_word <= nxt.code_word;
            req_chan.valid <= 1'b1;
            offered_items++;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      bit rdy;
      if (!hold_done && accepted_items >= 80) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (results_seen >= 60 && results_seen < 110) begin
         rdy = 1'b1;
      end else begin
         rdy = ($urandom_range(99) >= 28);
      end
      rsp_chan.ready <= rdy;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : main_sequence
      logic [SYM_W-1:0] live_syms[$];
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] len;
      int counted;
      int stream_idx;
      int loads;
      int encodes;
      int r;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_LOAD;
      req_chan.symbol = '0;
      req_chan.code_length = '0;
      req_chan.code_word = '0;
      rsp_chan.ready = 1'b0;

      // directed: empty table, ignored items, saturation, errors, flushes
      queue_item(CMD_ENCODE, 9'd5, 6'd0, 32'h0);
      queue_item(CMD_END, 9'd0, 6'd0, 32'h0);
      queue_item(CMD_SPARE, 9'd7, 6'd5, 32'hDEAD_BEEF);
      queue_item(CMD_LOAD, 9'd300, 6'd5, 32'h1F);
      queue_item(CMD_LOAD, 9'd0, 6'd32, 32'hFFFF_FFFF);
      queue_item(CMD_ENCODE, 9'd0, 6'd0, 32'h0);
      queue_item(CMD_LOAD, 9'd255, 6'd63, 32'h0F0F_A5C3);
      queue_item(CMD_LOAD, 9'd1, 6'd1, 32'hFFFF_FFFE);
      queue_item(CMD_LOAD, 9'd2, 6'd3, 32'h5);
      queue_item(CMD_ENCODE, 9'd1, 6'd0, 32'h0);
      queue_item(CMD_ENCODE, 9'd255, 6'd0, 32'h0);
      queue_item(CMD_ENCODE, 9'd2, 6'd0, 32'h0);
      queue_item(CMD_ENCODE, 9'd511, 6'd63, 32'hFFFF_FFFF);
      queue_item(CMD_ENCODE, EOS_SYMBOL, 6'd0, 32'h0);
      queue_item(CMD_END, 9'd0, 6'd0, 32'h0);
      queue_item(CMD_LOAD, EOS_SYMBOL, 6'd7, 32'h55);
      queue_item(CMD_ENCODE, 9'd2, 6'd0, 32'h0);
      queue_item(CMD_ENCODE, EOS_SYMBOL, 6'd0, 32'h0);
      queue_item(CMD_END, 9'd0, 6'd0, 32'h0);
      queue_item(CMD_LOAD, EOS_SYMBOL, 6'd8, 32'hA5);
      queue_item(CMD_END, 9'd0, 6'd0, 32'h0);
      queue_item(CMD_LOAD, 9'd0, 6'd0, 32'hFFFF_FFFF);
      queue_item(CMD_ENCODE, 9'd0, 6'd0, 32'h0);
      queue_item(CMD_LOAD, EOS_SYMBOL, 6'd0, 32'h0);
      queue_item(CMD_END, 9'd0, 6'd0, 32'h0);

      // random streams: reload part of the table, encode, then end the stream
      counted = 0;
      stream_idx = 0;
      while (counted < 85) begin
         loads = $urandom_range(6, 1);
         for (int i = 0; i < loads; i++) begin
            r = $urandom_range(99);
            if (r < 8) sym = SYM_W'($urandom_range(511));
            else if (r < 25) sym = EOS_SYMBOL;
            else sym = SYM_W'($urandom_range(ALPHABET_SIZE - 1));
            r = $urandom_range(99);
            if (r < 8) len = LEN_W'($urandom_range(63));
            else if (r < 12) len = '0;
            else if (r < 30) len = LEN_W'($urandom_range(32, 13));
            else len = LEN_W'($urandom_range(12, 1));
            queue_item(CMD_LOAD, sym, len, $urandom, (stream_idx == 3 && i == 0));
            if (sym <= ALPHABET_SIZE) counted++;
            if (sym < ALPHABET_SIZE && len != 0) live_syms.push_back(sym);
         end
         encodes = $urandom_range(16, 3);
         for (int i = 0; i < encodes; i++) begin
            r = $urandom_range(99);
            if (r < 3) begin
               queue_item(CMD_SPARE, SYM_W'($urandom_range(511)),
                          LEN_W'($urandom_range(63)), $urandom);
            end else begin
               if (r < 88 && live_syms.size() > 0)
                  sym = live_syms[$urandom_range(live_syms.size() - 1)];
               else
                  sym = SYM_W'($urandom_range(511));
               queue_item(CMD_ENCODE, sym, LEN_W'($urandom_range(63)), $urandom);
               counted++;
            end
         end
         queue_item(CMD_END, SYM_W'($urandom_range(511)), LEN_W'($urandom_range(63)),
                    $urandom);
         counted++;
         stream_idx++;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || accepted_items != offered_items ||
             expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
